FILE: sv/pbds_pkg.sv
`timescale 1ns / 1ps

package pbds_pkg;

    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;

    // One slot of the finish-time chain.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] finish;
    } t_entry;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              retire;
        logic              shift;
        logic [TIME_W-1:0] arrival;
    } t_cell_ctrl;

endpackage

FILE: sv/pbds_cell.sv
`timescale 1ns / 1ps

module pbds_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbds_pkg::t_cell_ctrl i_ctrl,
    input  pbds_pkg::t_entry   i_prev,
    output pbds_pkg::t_entry   o_entry
);
    import pbds_pkg::*;

    logic              r_valid;
    logic [TIME_W-1:0] r_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev.valid;
        end else if (i_ctrl.retire && r_valid && (r_finish <= i_ctrl.arrival)) begin
            // The packet held here has completed by the time the new one arrives.
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_finish <= i_prev.finish;
        end
    end

    assign o_entry.valid  = r_valid;
    assign o_entry.finish = r_finish;

endmodule

FILE: sv/packet_buffer_drop_scheduler.sv
`timescale 1ns / 1ps

// Single-server packet buffer with drop on overflow.
// A packet is presented on i_arrival_time / i_duration and taken at a rising
// edge where start is high and busy is low. After the retire and push states
// the result is on o_accepted / o_start_time for exactly one cycle, marked by
// o_result_valid; o_start_time is zero for a dropped packet. The receiver
// cannot stall. In the retire state every cell compares its finish time
// against the arrival time and retires itself; in the push state the
// admission decision, the saturating add and the chain shift happen. busy is
// high during those states and the next packet can be taken in the cycle that
// busy drops, which is also the result cycle, so no new packet is taken before
// the last one's result is out. The finish times sit in a chain of MAX_DEPTH
// cells, newest at cell 0. Finish times only grow toward the newest entry, so
// retired cells always form the oldest end of the chain and the live entries
// stay packed from cell 0. i_cfg_we writes the capacity register; the user
// must write it only while the block is idle; the block does not enforce it.
// Values above MAX_DEPTH act as MAX_DEPTH and zero drops every packet.
// Reset (synchronous, active low) empties the chain, sets the capacity to 64
// and returns the sequencer to idle; no clearing pass is needed.
module packet_buffer_drop_scheduler #(
    parameter int MAX_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pbds_pkg::TIME_W-1:0]  i_arrival_time,
    input  logic [pbds_pkg::DUR_W-1:0]   i_duration,
    input  logic                         i_cfg_we,
    input  logic [pbds_pkg::CAP_W-1:0]   i_cfg_wdata,
    output logic                         o_result_valid,
    output logic                         o_accepted,
    output logic [pbds_pkg::TIME_W-1:0]  o_start_time
);
    import pbds_pkg::*;

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(MAX_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RETIRE = 3'b010,
        S_PUSH   = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_arrival;
    logic [DUR_W-1:0]   r_dur;
    logic [CAP_W-1:0]   r_cap;
    logic               r_result_valid;
    logic               r_accepted;
    logic [TIME_W-1:0]  r_start_time;

    t_cell_ctrl         w_ctrl;
    t_entry             w_new;
    t_entry             w_chain [MAX_DEPTH+1];
    logic [MAX_DEPTH-1:0] w_alive;

    logic [CMP_W-1:0]   w_cap_ext;
    logic [CMP_W-1:0]   w_cap_eff;
    logic [CMP_W-1:0]   w_cap_last;
    logic               w_admit;
    logic [TIME_W-1:0]  w_start;
    logic [TIME_W:0]    w_sum;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_RETIRE;
            S_RETIRE: n_state = S_PUSH;
            S_PUSH:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cap          <= CAP_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= (r_state == S_PUSH);
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_arrival <= i_arrival_time;
            r_dur     <= i_duration;
        end
        if (r_state == S_PUSH) begin
            r_accepted   <= w_admit;
            r_start_time <= w_admit ? w_start : '0;
        end
    end

    // Admission: after retirement the live entries occupy cells 0..count-1,
    // so the buffer has room exactly when the cell at capacity-1 is empty.
    assign w_cap_ext  = CMP_W'(r_cap);
    assign w_cap_eff  = (w_cap_ext > DEPTH_C) ? DEPTH_C : w_cap_ext;
    assign w_cap_last = w_cap_eff - CMP_W'(1);
    assign w_admit    = (w_cap_eff != '0) && !w_alive[w_cap_last[IDX_W-1:0]];

    assign w_start = w_alive[0] ? w_chain[1].finish : r_arrival;
    assign w_sum   = {1'b0, w_start} + (TIME_W + 1)'(r_dur);

    assign w_new.valid  = 1'b1;
    assign w_new.finish = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];

    assign w_ctrl.retire  = (r_state == S_RETIRE);
    assign w_ctrl.shift   = (r_state == S_PUSH) && w_admit;
    assign w_ctrl.arrival = r_arrival;

    assign w_chain[0] = w_new;

    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        pbds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_chain[g]),
            .o_entry (w_chain[g+1])
        );
        assign w_alive[g] = w_chain[g+1].valid;
    end

    assign o_result_valid = r_result_valid;
    assign o_accepted     = r_accepted;
    assign o_start_time   = r_start_time;

endmodule

FILE: sv/pbds_chk.sv
`timescale 1ns / 1ps

module pbds_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         i_busy,
    input logic                         i_result_valid,
    input logic                         i_accepted,
    input logic [pbds_pkg::TIME_W-1:0]  i_start_time
);
    import pbds_pkg::*;

    // A taken transaction's result strobe follows its retire and push states.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |-> ##3 i_result_valid)
        else $error("result did not follow accepted transaction");

    // Taking a transaction makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("busy not raised after transaction");

    // Results never come back to back.
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |=> !i_result_valid)
        else $error("back-to-back results");

    // A dropped packet reports a zero start time.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && !i_accepted) |-> (i_start_time == '0))
        else $error("dropped packet with nonzero start time");

    // The result cycle is the first idle cycle after the work.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |-> !i_busy)
        else $error("busy while result is shown");

endmodule

bind packet_buffer_drop_scheduler pbds_chk u_pbds_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_result_valid (o_result_valid),
    .i_accepted     (o_accepted),
    .i_start_time   (o_start_time)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pbds_pkg::*;

    localparam int DEPTH          = 64;
    localparam int RANDOM_PACKETS = 1100;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DIRECTED_ROWS  = 24;

    typedef enum logic {ROW_PACKET, ROW_CAPACITY} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [TIME_W-1:0] arrival;
        logic [DUR_W-1:0]  duration;
        logic [CAP_W-1:0]  capacity;
        logic              typed;
        logic              exp_accepted;
        logic [TIME_W-1:0] exp_start;
    } t_stim_row;

    typedef struct packed {
        logic              accepted;
        logic [TIME_W-1:0] start_time;
    } t_admission;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [TIME_W-1:0] i_arrival_time;
    logic [DUR_W-1:0]  i_duration;
    logic              i_cfg_we;
    logic [CAP_W-1:0]  i_cfg_wdata;
    logic              o_result_valid;
    logic              o_accepted;
    logic [TIME_W-1:0] o_start_time;

    // Predictor state: finish times of buffered packets, oldest first.
    logic [TIME_W-1:0] finish_times[$];
    logic [CAP_W-1:0]  model_capacity;
    t_admission        pending_decisions[$];

    t_stim_row directed [DIRECTED_ROWS];
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;

    packet_buffer_drop_scheduler #(
        .MAX_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_arrival_time (i_arrival_time),
        .i_duration     (i_duration),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_accepted     (o_accepted),
        .o_start_time   (o_start_time)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void predict_admission(input logic [TIME_W-1:0] arr,
                                              input logic [DUR_W-1:0] dur,
                                              output t_admission res);
        logic [TIME_W:0] sum;
        int              limit;
        while (finish_times.size() > 0 && finish_times[0] <= arr)
            void'(finish_times.pop_front());
        limit = (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
        if (finish_times.size() < limit) begin
            res.accepted   = 1'b1;
            res.start_time = (finish_times.size() == 0) ? arr : finish_times[$];
            sum = {1'b0, res.start_time} + {{(TIME_W - DUR_W + 1){1'b0}}, dur};
            finish_times.push_back(sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0]);
        end else begin
            res = '0;
        end
    endfunction

    task automatic send_packet(input logic [TIME_W-1:0] arr, input logic [DUR_W-1:0] dur,
                               input logic typed, input logic exp_accepted,
                               input logic [TIME_W-1:0] exp_start);
        t_admission predicted;
        @(negedge i_clk);
        start          <= 1'b1;
        i_arrival_time <= arr;
        i_duration     <= dur;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_admission(arr, dur, predicted);
        if (typed)
            pending_decisions.push_back({exp_accepted, exp_start});
        else
            pending_decisions.push_back(predicted);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic pace_sender();
        if (burst_left == 0) begin
            idle_cycles($urandom_range(0, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic drain_decisions();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_decisions();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_capacity = value;
    endtask

    always @(posedge i_clk) begin : result_check
        t_admission want;
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_result_valid)) begin
                $error("o_result_valid is unknown");
                error_count++;
            end else if (o_result_valid) begin
                if (pending_decisions.size() == 0) begin
                    $error("unexpected transaction: accepted %0d start_time 0x%08h",
                           o_accepted, o_start_time);
                    error_count++;
                end else begin
                    want = pending_decisions.pop_front();
                    if (o_accepted !== want.accepted) begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, o_accepted);
                        error_count++;
                    end
                    if (o_start_time !== want.start_time) begin
                        $error("start_time: expected 0x%08h, actual 0x%08h",
                               want.start_time, o_start_time);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] cur_arrival;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] back;
        logic [CAP_W-1:0]  cap;
        int                sent;
        int                dur_max;
        int                inc_max;

        start          = 1'b0;
        i_arrival_time = '0;
        i_duration     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_rst_n        = 1'b0;
        finish_times.delete();
        model_capacity = CAP_RESET;

        directed[0]  = '{ROW_PACKET,   32'd0,         16'd0,      7'd0,   1'b1, 1'b1, 32'd0};
        directed[1]  = '{ROW_PACKET,   32'd0,         16'hFFFF,   7'd0,   1'b1, 1'b1, 32'd0};
        directed[2]  = '{ROW_PACKET,   32'd5,         16'd10,     7'd0,   1'b0, 1'b0, 32'd0};
        directed[3]  = '{ROW_PACKET,   32'hFFFF_FFF0, 16'hFFFF,   7'd0,   1'b1, 1'b1,
                         32'hFFFF_FFF0};
        directed[4]  = '{ROW_PACKET,   32'hFFFF_FFF0, 16'd1,      7'd0,   1'b1, 1'b1, TIME_MAX};
        directed[5]  = '{ROW_PACKET,   TIME_MAX,      16'd0,      7'd0,   1'b1, 1'b1, TIME_MAX};
        // Arrival goes backward while a saturated entry is held.
        directed[6]  = '{ROW_PACKET,   32'd0,         16'd100,    7'd0,   1'b0, 1'b0, 32'd0};
        directed[7]  = '{ROW_CAPACITY, 32'd0,         16'd0,      7'd0,   1'b0, 1'b0, 32'd0};
        directed[8]  = '{ROW_PACKET,   TIME_MAX,      16'd5,      7'd0,   1'b1, 1'b0, 32'd0};
        directed[9]  = '{ROW_CAPACITY, 32'd0,         16'd0,      7'd1,   1'b0, 1'b0, 32'd0};
        directed[10] = '{ROW_PACKET,   32'd100,       16'd50,     7'd0,   1'b1, 1'b1, 32'd100};
        directed[11] = '{ROW_PACKET,   32'd120,       16'd1,      7'd0,   1'b1, 1'b0, 32'd0};
        directed[12] = '{ROW_PACKET,   32'd150,       16'd3,      7'd0,   1'b0, 1'b0, 32'd0};
        directed[13] = '{ROW_CAPACITY, 32'd0,         16'd0,      7'd64,  1'b0, 1'b0, 32'd0};
        directed[14] = '{ROW_PACKET,   32'd200,       16'd1000,   7'd0,   1'b0, 1'b0, 32'd0};
        directed[15] = '{ROW_PACKET,   32'd200,       16'd1000,   7'd0,   1'b0, 1'b0, 32'd0};
        directed[16] = '{ROW_PACKET,   32'd200,       16'd1000,   7'd0,   1'b0, 1'b0, 32'd0};
        directed[17] = '{ROW_PACKET,   32'd200,       16'd1000,   7'd0,   1'b0, 1'b0, 32'd0};
        // Capacity drops below the four entries already held.
        directed[18] = '{ROW_CAPACITY, 32'd0,         16'd0,      7'd2,   1'b0, 1'b0, 32'd0};
        directed[19] = '{ROW_PACKET,   32'd300,       16'd7,      7'd0,   1'b1, 1'b0, 32'd0};
        directed[20] = '{ROW_PACKET,   32'd2200,      16'd7,      7'd0,   1'b1, 1'b0, 32'd0};
        directed[21] = '{ROW_PACKET,   32'd3200,      16'd7,      7'd0,   1'b0, 1'b0, 32'd0};
        directed[22] = '{ROW_CAPACITY, 32'd0,         16'd0,      7'd127, 1'b0, 1'b0, 32'd0};
        directed[23] = '{ROW_PACKET,   32'd3200,      16'hFFFF,   7'd0,   1'b0, 1'b0, 32'd0};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed[r].kind == ROW_CAPACITY)
                write_capacity(directed[r].capacity);
            else
                send_packet(directed[r].arrival, directed[r].duration, directed[r].typed,
                            directed[r].exp_accepted, directed[r].exp_start);
        end

        sent        = 0;
        cur_arrival = 32'd3200;
        while (sent < RANDOM_PACKETS) begin
            case ($urandom_range(0, 3))
                0: begin
                    base = cur_arrival;
                end
                1: begin
                    base = $urandom();
                end
                2: begin
                    base = TIME_MAX - $urandom_range(0, 200000);
                end
                default: begin
                    base = $urandom_range(0, 5000);
                end
            endcase
            if (base < cur_arrival || cur_arrival > 32'hF000_0000) begin
                // Finish times above the new base would block it for good. A packet
                // at the top of the time range retires them all, and with capacity
                // zero it is dropped and leaves the buffer empty.
                write_capacity('0);
                send_packet(TIME_MAX, DUR_W'($urandom()), 1'b1, 1'b0, '0);
                sent++;
            end
            cur_arrival = base;

            case ($urandom_range(0, 5))
                0: cap = '0;
                1: cap = CAP_W'(1);
                2: cap = CAP_W'(DEPTH);
                3: cap = '1;
                4: cap = CAP_W'($urandom_range(DEPTH + 1, 126));
                default: cap = CAP_W'($urandom_range(2, DEPTH - 1));
            endcase
            write_capacity(cap);

            case ($urandom_range(0, 3))
                0: dur_max = 0;
                1: dur_max = 15;
                2: dur_max = 1000;
                default: dur_max = 65535;
            endcase
            // A zero or small arrival step keeps the buffer filling up.
            case ($urandom_range(0, 3))
                0: inc_max = 0;
                1: inc_max = dur_max / 4;
                2: inc_max = dur_max;
                default: inc_max = dur_max * 2;
            endcase

            repeat ($urandom_range(20, 100)) begin
                pace_sender();
                if ($urandom_range(0, 24) == 0) begin
                    back = $urandom_range(0, 2000);
                    arr  = (cur_arrival > back) ? cur_arrival - back : '0;
                end else begin
                    step        = $urandom_range(0, inc_max);
                    cur_arrival = (cur_arrival > TIME_MAX - step) ? TIME_MAX
                                                                  : cur_arrival + step;
                    arr         = cur_arrival;
                end
                send_packet(arr, DUR_W'($urandom_range(0, dur_max)), 1'b0, 1'b0, '0);
                sent++;
            end
        end

        drain_decisions();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
